// File: rtl/bss_pkg.sv
`timescale 1ns / 1ps

package bss_pkg;

  localparam int MAX_NEEDLE = 16;
  localparam longint MAX_HAYSTACK = 65536;

  localparam int NEEDLE_LEN_W = $clog2(MAX_NEEDLE + 1);
  localparam int HAY_COUNT_W = $clog2(MAX_HAYSTACK + 1);
  localparam int POS_W = 16;

  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_NEEDLE   = 2'd1,
    KIND_HAYSTACK = 2'd2,
    KIND_FINISH   = 2'd3
  } kind_t;

  typedef struct packed {
    logic clear;
    logic needle_shift;
    logic window_shift;
  } cell_ctrl_t;

endpackage

// File: rtl/bss_cell.sv
`timescale 1ns / 1ps

module bss_cell (
  input  logic                clk,
  input  logic                rst,
  input  bss_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          needle_in,
  input  logic [7:0]          window_in,
  input  logic                active_in,
  output logic [7:0]          needle_out,
  output logic [7:0]          window_out,
  output logic                active_out,
  output logic                hit
);

  logic [7:0] needle_byte;
  logic [7:0] window_byte;
  logic       active;

  always_ff @(posedge clk) begin
    if (ctrl.needle_shift) begin
      needle_byte <= needle_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      window_byte <= 8'd0;
      active      <= 1'b0;
    end else begin
      if (ctrl.window_shift) begin
        window_byte <= window_in;
      end
      if (ctrl.needle_shift) begin
        active <= active_in;
      end
    end
  end

  assign needle_out = needle_byte;
  assign window_out = window_byte;
  assign active_out = active;
  assign hit        = !active || (needle_byte == window_byte);

endmodule

// File: rtl/byte_substring_search_unit.sv
`timescale 1ns / 1ps

// out_valid rises once a finish transaction accepted at the input has passed the token
// register (tok) and loaded the output register.
// One transaction per cycle while in_ready is high; the row of compare cells checks the
// whole window against the needle in the cycle after each haystack byte.
// Input stalls only while a second result is ready and the output register is full.
// Reset is synchronous and clears the search and sets the direction to forward.
module byte_substring_search_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [15:0] match_position,
  output logic        needle_overflow,
  output logic        haystack_overflow
);

  localparam int N = bss_pkg::MAX_NEEDLE;
  localparam int LW = bss_pkg::NEEDLE_LEN_W;
  localparam int CW = bss_pkg::HAY_COUNT_W;
  localparam int PW = bss_pkg::POS_W;

  typedef struct packed {
    logic              valid;
    bss_pkg::kind_t    op;
    logic              dir;
    logic [PW-1:0]     pos;
    logic              needle_empty;
    logic              empty_found;
    logic              ntl;
    logic              hov;
  } token_t;

  logic              search_direction;
  logic [LW-1:0]     needle_length;
  logic [CW-1:0]     haystack_count;
  logic              needle_too_long;
  logic              haystack_too_long;
  logic              match_seen;
  logic [PW-1:0]     kept_position;
  token_t            tok;
  token_t            tok_next;

  logic              stall;
  logic              accept;
  bss_pkg::kind_t    in_kind;
  logic              needle_take;
  logic              hay_take;
  logic [CW-1:0]     count_inc;
  bss_pkg::cell_ctrl_t ctrl;

  logic [7:0]        needle_link [N+1];
  logic [7:0]        window_link [N+1];
  logic              active_link [N+1];
  logic [N-1:0]      hits;
  logic              all_hit;

  assign stall    = tok.valid && (tok.op == bss_pkg::KIND_FINISH) && out_valid && !out_ready;
  assign in_ready = !stall;
  assign accept   = in_valid && !stall;
  assign in_kind  = bss_pkg::kind_t'(kind);

  assign needle_take = accept && (in_kind == bss_pkg::KIND_NEEDLE) &&
                       (haystack_count == '0) && !haystack_too_long &&
                       (needle_length < LW'(N));
  assign hay_take    = accept && (in_kind == bss_pkg::KIND_HAYSTACK) &&
                       (haystack_count < CW'(bss_pkg::MAX_HAYSTACK));
  assign count_inc   = haystack_count + CW'(1);

  assign ctrl.clear        = accept && (in_kind == bss_pkg::KIND_START);
  assign ctrl.needle_shift = needle_take;
  assign ctrl.window_shift = hay_take;

  assign needle_link[0] = data_byte;
  assign window_link[0] = data_byte;
  assign active_link[0] = 1'b1;

  for (genvar k = 0; k < N; k++) begin : g_cell
    bss_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .needle_in  (needle_link[k]),
      .window_in  (window_link[k]),
      .active_in  (active_link[k]),
      .needle_out (needle_link[k+1]),
      .window_out (window_link[k+1]),
      .active_out (active_link[k+1]),
      .hit        (hits[k])
    );
  end

  assign all_hit = &hits;

  always_comb begin
    tok_next              = '0;
    tok_next.op           = in_kind;
    tok_next.dir          = search_direction;
    tok_next.needle_empty = (needle_length == '0);
    tok_next.ntl          = needle_too_long;
    tok_next.hov          = haystack_too_long;
    case (in_kind)
      bss_pkg::KIND_START: begin
        tok_next.valid = accept;
      end
      bss_pkg::KIND_HAYSTACK: begin
        tok_next.valid = hay_take && (needle_length != '0) && !needle_too_long &&
                         (count_inc >= CW'(needle_length));
        tok_next.pos   = PW'(count_inc - CW'(needle_length));
      end
      bss_pkg::KIND_FINISH: begin
        tok_next.valid       = accept;
        tok_next.empty_found = !search_direction || (haystack_count != '0);
        tok_next.pos         = search_direction ? PW'(haystack_count - CW'(1)) : '0;
      end
      default: begin
        tok_next.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_direction  <= 1'b0;
      needle_length     <= '0;
      haystack_count    <= '0;
      needle_too_long   <= 1'b0;
      haystack_too_long <= 1'b0;
      tok.valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        search_direction <= cfg_data;
      end
      if (!stall) begin
        tok <= tok_next;
      end
      if (ctrl.clear) begin
        needle_length     <= '0;
        haystack_count    <= '0;
        needle_too_long   <= 1'b0;
        haystack_too_long <= 1'b0;
      end else if (accept && (in_kind == bss_pkg::KIND_NEEDLE) &&
                   (haystack_count == '0) && !haystack_too_long) begin
        if (needle_take) begin
          needle_length <= needle_length + LW'(1);
        end else begin
          needle_too_long <= 1'b1;
        end
      end else if (accept && (in_kind == bss_pkg::KIND_HAYSTACK)) begin
        if (hay_take) begin
          haystack_count <= count_inc;
        end else begin
          haystack_too_long <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_seen    <= 1'b0;
      kept_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (!stall && tok.valid && (tok.op == bss_pkg::KIND_FINISH)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (!stall && tok.valid) begin
        case (tok.op)
          bss_pkg::KIND_START: begin
            match_seen    <= 1'b0;
            kept_position <= '0;
          end
          bss_pkg::KIND_HAYSTACK: begin
            if (all_hit && (tok.dir || !match_seen)) begin
              match_seen    <= 1'b1;
              kept_position <= tok.pos;
            end
          end
          bss_pkg::KIND_FINISH: begin
            needle_overflow   <= tok.ntl;
            haystack_overflow <= tok.hov;
            if (tok.ntl) begin
              found          <= 1'b0;
              match_position <= '0;
            end else if (tok.needle_empty) begin
              found          <= tok.empty_found;
              match_position <= tok.empty_found ? tok.pos : '0;
            end else begin
              found          <= match_seen;
              match_position <= match_seen ? kept_position : '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bss_pkg::*;

  localparam bit DIR_FORWARD = 1'b0;
  localparam bit DIR_REVERSE = 1'b1;
  localparam int CYCLE_LIMIT = 200_000;
  localparam logic [15:0] READY_PATTERN = 16'b1001_1100_0011_0101;

  typedef struct {
    kind_t      k;
    logic [7:0] b;
  } search_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] position;
    logic        needle_ovf;
    logic        hay_ovf;
  } search_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = KIND_START;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [15:0] match_position;
  logic        needle_overflow;
  logic        haystack_overflow;

  search_item_t   pending_items[$];
  search_report_t expected_reports[$];
  search_item_t   cur_item;
  int             burst_left = 1;
  int             gap_left = 0;
  int             queued_count = 0;
  int             mismatch_count = 0;
  int             cycle_count = 0;

  bit          search_dir = DIR_FORWARD;
  logic [7:0]  needle_bytes[MAX_NEEDLE];
  int unsigned needle_len;
  logic [7:0]  window[MAX_NEEDLE];
  longint      hay_count;
  bit          hit_seen;
  logic [15:0] hit_pos;
  bit          needle_ovf;
  bit          hay_ovf;

  byte_substring_search_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .found            (found),
    .match_position   (match_position),
    .needle_overflow  (needle_overflow),
    .haystack_overflow(haystack_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_search();
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      needle_bytes[i] = 8'h00;
      window[i] = 8'h00;
    end
    needle_len = 0;
    hay_count = 0;
    hit_seen = 1'b0;
    hit_pos = 16'h0000;
    needle_ovf = 1'b0;
    hay_ovf = 1'b0;
  endfunction

  function automatic void advance_search(kind_t k, logic [7:0] b);
    search_report_t rep;
    bit window_hit;
    case (k)
      KIND_START: begin
        clear_search();
      end
      KIND_NEEDLE: begin
        if (hay_count == 0 && !hay_ovf) begin
          if (needle_len < MAX_NEEDLE) begin
            needle_bytes[needle_len] = b;
            needle_len++;
          end else begin
            needle_ovf = 1'b1;
          end
        end
      end
      KIND_HAYSTACK: begin
        if (hay_count >= MAX_HAYSTACK) begin
          hay_ovf = 1'b1;
        end else begin
          for (int i = MAX_NEEDLE - 1; i > 0; i--) window[i] = window[i - 1];
          window[0] = b;
          hay_count++;
          if (needle_len != 0 && !needle_ovf && hay_count >= needle_len) begin
            window_hit = 1'b1;
            for (int i = 0; i < needle_len; i++) begin
              if (needle_bytes[i] != window[needle_len - 1 - i]) window_hit = 1'b0;
            end
            if (window_hit && (search_dir == DIR_REVERSE || !hit_seen)) begin
              hit_seen = 1'b1;
              hit_pos = 16'(hay_count - needle_len);
            end
          end
        end
      end
      default: begin
        rep = '{found: 1'b0, position: 16'h0000, needle_ovf: needle_ovf, hay_ovf: hay_ovf};
        if (!needle_ovf) begin
          if (needle_len == 0) begin
            if (search_dir == DIR_FORWARD) begin
              rep.found = 1'b1;
            end else if (hay_count != 0) begin
              rep.found = 1'b1;
              rep.position = 16'(hay_count - 1);
            end
          end else if (hit_seen) begin
            rep.found = 1'b1;
            rep.position = hit_pos;
          end
        end
        expected_reports.push_back(rep);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      clear_search();
    end else begin
      if (in_valid && in_ready) advance_search(cur_item.k, cur_item.b);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          kind <= cur_item.k;
          data_byte <= cur_item.b;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    search_report_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transaction, expected none, got found=%0d position=%0d",
                   $time, found, match_position);
        end else begin
          want = expected_reports.pop_front();
          check_field("found", 16'(want.found), 16'(found));
          check_field("match_position", want.position, match_position);
          check_field("needle_overflow", 16'(want.needle_ovf), 16'(needle_overflow));
          check_field("haystack_overflow", 16'(want.hay_ovf), 16'(haystack_overflow));
        end
      end
      case (cycle_count[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready <= READY_PATTERN[cycle_count[3:0]];
        default: out_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void queue_item(kind_t k, logic [7:0] b);
    search_item_t it;
    it.k = k;
    it.b = b;
    pending_items.push_back(it);
    queued_count++;
  endfunction

  function automatic logic [7:0] pick_byte(bit wide, logic [7:0] a0, logic [7:0] a1);
    if (wide) return 8'($urandom);
    return ($urandom_range(0, 1) != 0) ? a0 : a1;
  endfunction

  function automatic void queue_random_search(bit close);
    int unsigned nlen;
    int unsigned hlen;
    int unsigned plant_at;
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] ndl[$];
    logic [7:0] hay[$];
    bit wide;
    wide = ($urandom_range(0, 4) == 0);
    a0 = 8'($urandom);
    a1 = 8'($urandom);
    case ($urandom_range(0, 9))
      0: nlen = 0;
      1: nlen = MAX_NEEDLE + $urandom_range(1, 3);
      2: nlen = MAX_NEEDLE;
      default: nlen = $urandom_range(1, 6);
    endcase
    hlen = $urandom_range(0, 40);
    repeat (nlen) ndl.push_back(pick_byte(wide, a0, a1));
    repeat (hlen) hay.push_back(pick_byte(wide, a0, a1));
    if (nlen > 0 && nlen <= MAX_NEEDLE && nlen <= hlen && $urandom_range(0, 1) != 0) begin
      plant_at = $urandom_range(0, hlen - nlen);
      for (int i = 0; i < nlen; i++) hay[plant_at + i] = ndl[i];
    end
    queue_item(KIND_START, 8'($urandom));
    foreach (ndl[i]) queue_item(KIND_NEEDLE, ndl[i]);
    foreach (hay[i]) begin
      queue_item(KIND_HAYSTACK, hay[i]);
      if ($urandom_range(0, 39) == 0) queue_item(KIND_NEEDLE, 8'($urandom));
    end
    if (close) begin
      queue_item(KIND_FINISH, 8'($urandom));
      if ($urandom_range(0, 7) == 0) queue_item(KIND_FINISH, 8'($urandom));
    end
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_direction(bit d);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= d;
    search_dir = d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_count;
    bit open_search;
    open_search = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty needle, match, late needle byte, repeated finish and
    // a direction change in the middle of a search.
    queue_item(KIND_FINISH, 8'h00);
    queue_item(KIND_START, 8'hFF);
    queue_item(KIND_NEEDLE, 8'h00);
    queue_item(KIND_NEEDLE, 8'hFF);
    queue_item(KIND_HAYSTACK, 8'h11);
    queue_item(KIND_HAYSTACK, 8'h00);
    queue_item(KIND_HAYSTACK, 8'hFF);
    queue_item(KIND_HAYSTACK, 8'h00);
    queue_item(KIND_HAYSTACK, 8'hFF);
    queue_item(KIND_FINISH, 8'hFF);
    queue_item(KIND_NEEDLE, 8'h55);
    queue_item(KIND_FINISH, 8'h00);
    set_direction(DIR_REVERSE);
    queue_item(KIND_HAYSTACK, 8'h00);
    queue_item(KIND_HAYSTACK, 8'hFF);
    queue_item(KIND_FINISH, 8'h00);
    queue_item(KIND_START, 8'h00);
    queue_item(KIND_FINISH, 8'h00);
    queue_item(KIND_HAYSTACK, 8'hAB);
    queue_item(KIND_HAYSTACK, 8'hCD);
    queue_item(KIND_FINISH, 8'h00);
    set_direction(DIR_FORWARD);

    queued_count = 0;
    while (queued_count < 2000) begin
      set_direction($urandom_range(0, 1) != 0 ? DIR_REVERSE : DIR_FORWARD);
      if (open_search) begin
        repeat ($urandom_range(0, 6)) queue_item(KIND_HAYSTACK, 8'($urandom));
        queue_item(KIND_FINISH, 8'($urandom));
      end
      phase_count = queued_count;
      while (queued_count - phase_count < 200) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_item(kind_t'($urandom_range(0, 3)), 8'($urandom));
        end else begin
          queue_random_search(1'b1);
        end
      end
      open_search = ($urandom_range(0, 1) != 0);
      queue_random_search(!open_search);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
